@@ hw/rtl/md5_message_digest_unit_macros.svh @@
// assertion macros for the md5 unit checker
`ifndef MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define MD5_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ hw/rtl/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// md5 package
// round constants, shift amounts and shared types
// ----------------------------------------------------------------------------
package md5_pkg;
   localparam int unsigned BufDepth  = 16;
   localparam int unsigned WordWidth = 32;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;

   // memory write request from the control unit
   typedef struct packed {
      logic       en;
      logic [3:0] addr;
      logic [3:0] be;
      logic [31:0] data;
   } buf_wr_type;

   function automatic logic [31:0] sine_k(input logic [5:0] r);
      logic [31:0] k;
      begin
         case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
         endcase
         return k;
      end
   endfunction

   function automatic logic [4:0] rot_s(input logic [5:0] r);
      logic [4:0] s;
      begin
         case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
            4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
            4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
            4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
         endcase
         return s;
      end
   endfunction

   // message word index used in round r
   function automatic logic [3:0] msg_idx(input logic [5:0] r);
      logic [3:0] g;
      begin
         case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(5 * r[3:0] + 1);
            2'd2: g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
         endcase
         return g;
      end
   endfunction
endpackage

@@ hw/rtl/md5_buf.sv @@
// ----------------------------------------------------------------------------
// md5 block buffer
// 16 x 32 byte-writable memory, one write and one registered read a cycle
// ----------------------------------------------------------------------------
module md5_buf (
   input  logic                 clock,
   input  md5_pkg::buf_wr_type  wr,
   input  logic [3:0]           rd_addr,
   output logic [31:0]          rd_data
);
   import md5_pkg::*;

   logic [31:0] mem [BufDepth];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int i = 0; i < 4; i++) begin
            if (wr.be[i]) mem[wr.addr][i*8 +: 8] <= wr.data[i*8 +: 8];
         end
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/md5_round.sv @@
// ----------------------------------------------------------------------------
// md5 round unit
// one md5 step per cycle while step is high on the working registers, then chaining update
// ----------------------------------------------------------------------------
module md5_round (
   input  logic        clock,
   input  logic        load,
   input  logic        step,
   input  logic        finish,
   input  logic        init,
   input  logic [5:0]  round,
   input  logic [31:0] msg_word,
   output logic [31:0] h0,
   output logic [31:0] h1,
   output logic [31:0] h2,
   output logic [31:0] h3
);
   import md5_pkg::*;

   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] h_ff [4];
   logic [31:0] f, t, rot;
   logic [4:0]  s;

   always_comb begin
      case (round[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      s   = rot_s(round);
      t   = a_ff + f + sine_k(round) + msg_word;
      rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
   end

   always_ff @(posedge clock) begin
      if (init) begin
         h_ff[0] <= IV0; h_ff[1] <= IV1; h_ff[2] <= IV2; h_ff[3] <= IV3;
      end else if (finish) begin
         h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
      end
      if (load) begin
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2]; d_ff <= h_ff[3];
      end else if (step) begin
         a_ff <= d_ff; d_ff <= c_ff; c_ff <= b_ff; b_ff <= b_ff + rot;
      end
   end

   assign h0 = h_ff[0];
   assign h1 = h_ff[1];
   assign h2 = h_ff[2];
   assign h3 = h_ff[3];
endmodule

@@ hw/rtl/md5_message_digest_unit.sv @@
// ----------------------------------------------------------------------------
// md5 message digest unit
// byte-serial md5 with block buffer memory and a one-round-per-cycle core
// ----------------------------------------------------------------------------
// usage:
//  - req_ channel: one transfer per message byte (req_has_byte), req_is_last
//    ends the message; a last transfer may carry no byte
//  - rsp_ channel: four transfers per message, digest words 0..3, word 3
//    flagged by rsp_last_word
//  - a byte that neither completes a block nor ends the message keeps req_ready high
//  - a byte that completes a block holds req_ready low while the core is
//    loaded, 64 rounds run, each with a buffer read issued the cycle
//    before it, and the chaining update is done
//  - padding writes one byte per cycle through the same path; after a last
//    transfer the pad and length bytes are written and every block they
//    complete is compressed before the first digest word, then four result
//    transfers follow while rsp_ready is high
//  - one message is worked at a time; the next request is taken the cycle
//    after the fourth digest word transfers
//  - reset (synchronous, active high) restores the initial chaining words,
//    zeroes the counts; buffer contents stay undefined and are never read
//    before being written
//  - while rsp_ready is low the current digest word holds and no request is
//    taken until all four words have transferred
// ----------------------------------------------------------------------------
module md5_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import md5_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_RND   = 6'b001000,
      ST_FIN   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] count_ff, count_in;
   logic [5:0]  fill_ff, fill_in;
   logic [6:0]  rnd_ff, rnd_in;      // issue counter, one ahead of the core
   logic        mark_ff, mark_in;    // 0x80 marker still to be written
   logic        wrap_ff, wrap_in;    // length goes into the following block
   logic        pend_ff, pend_in;    // message ended, digest pending
   logic [1:0]  widx_ff, widx_in;
   logic [63:0] bits_ff, bits_in;

   buf_wr_type  wr;
   logic [31:0] rd_data;
   logic [31:0] h0, h1, h2, h3;
   logic        load, step, finish, init;
   logic [7:0]  wbyte;
   logic        wbyte_en;
   logic [5:0]  core_round;

   md5_buf u_buf (
      .clock  (clock),
      .wr     (wr),
      .rd_addr(msg_idx(rnd_ff[5:0])),
      .rd_data(rd_data)
   );

   md5_round u_round (
      .clock   (clock),
      .load    (load),
      .step    (step),
      .finish  (finish),
      .init    (init),
      .round   (core_round),
      .msg_word(rd_data),
      .h0(h0), .h1(h1), .h2(h2), .h3(h3)
   );

   assign core_round = 6'(rnd_ff - 7'd1);
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUT);
   assign rsp_word_index = widx_ff;
   assign rsp_last_word  = (widx_ff == 2'd3);
   always_comb begin
      case (widx_ff)
         2'd0: rsp_digest_word = h0;
         2'd1: rsp_digest_word = h1;
         2'd2: rsp_digest_word = h2;
         default: rsp_digest_word = h3;
      endcase
   end

   // padding byte for the current fill position: length bytes at 56..63
   // of the block that carries the length, zeros elsewhere
   logic [7:0] pad_byte;
   always_comb begin
      if (fill_ff >= 6'd56 && !wrap_ff) pad_byte = bits_ff[{fill_ff[2:0], 3'b000} +: 8];
      else pad_byte = 8'h00;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      rnd_in   = rnd_ff;
      mark_in  = mark_ff;
      wrap_in  = wrap_ff;
      pend_in  = pend_ff;
      widx_in  = widx_ff;
      bits_in  = bits_ff;
      wbyte    = 8'h00;
      wbyte_en = 1'b0;
      load = 1'b0; step = 1'b0; finish = 1'b0;
      init = reset;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  wbyte_en = 1'b1;
                  wbyte    = req_data_byte;
                  count_in = count_ff + 64'd1;
               end
               if (req_is_last) begin
                  pend_in = 1'b1;
                  mark_in = 1'b1;
                  bits_in = {count_in[60:0], 3'b000};
               end
               if (req_has_byte && fill_ff == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req_is_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wbyte_en = 1'b1;
            if (mark_ff) begin
               // marker goes where the message ended
               wbyte   = 8'h80;
               mark_in = 1'b0;
               wrap_in = (fill_ff >= 6'd56);
            end else begin
               wbyte = pad_byte;
            end
            if (fill_ff == 6'd63) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            load   = 1'b1;
            rnd_in = rnd_ff + 7'd1;
            state_in = ST_RND;
         end
         ST_RND: begin
            step   = 1'b1;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd64) state_in = ST_FIN;
         end
         ST_FIN: begin
            // block done: take more bytes, keep padding, or emit the digest
            finish = 1'b1;
            rnd_in = 7'd0;
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (mark_ff || wrap_ff) begin
               state_in = ST_PAD;
               wrap_in  = 1'b0;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               widx_in = widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  state_in = ST_IDLE;
                  init     = 1'b1;
                  pend_in  = 1'b0;
                  count_in = 64'd0;
                  fill_in  = 6'd0;
                  bits_in  = 64'd0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (wbyte_en) fill_in = 6'(fill_ff + 6'd1);
   end

   // byte lane write at the current fill position
   always_comb begin
      wr.en   = wbyte_en;
      wr.addr = fill_ff[5:2];
      wr.be   = 4'b0001 << fill_ff[1:0];
      wr.data = {4{wbyte}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 64'd0;
         fill_ff  <= 6'd0;
         rnd_ff   <= 7'd0;
         mark_ff  <= 1'b0;
         wrap_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         widx_ff  <= 2'd0;
         bits_ff  <= 64'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         rnd_ff   <= rnd_in;
         mark_ff  <= mark_in;
         wrap_ff  <= wrap_in;
         pend_ff  <= pend_in;
         widx_ff  <= widx_in;
         bits_ff  <= bits_in;
      end
   end
endmodule

@@ hw/rtl/md5_message_digest_unit_checker.sv @@
// ----------------------------------------------------------------------------
// md5 unit port checker
// port-level checks on the result sequence
// ----------------------------------------------------------------------------
`include "md5_message_digest_unit_macros.svh"
module md5_message_digest_unit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word
);
   `MD5_ASSERT_IMP(a_last_is_three, clock, reset, rsp_valid, rsp_last_word == &rsp_word_index)
   `MD5_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `MD5_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_digest_word))
   `MD5_ASSERT_NEXT(a_word_next, clock, reset, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid)
endmodule

bind md5_message_digest_unit md5_message_digest_unit_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_digest_word(rsp_digest_word),
   .rsp_word_index(rsp_word_index), .rsp_last_word(rsp_last_word)
);

@@ tb/md5_message_digest_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5 message digest unit testbench
// byte-serial messages are driven with random bursts and gaps; a local md5
// model predicts the four digest words of every message, and each word that
// leaves the unit is compared field by field in order
// ----------------------------------------------------------------------------
module md5_message_digest_unit_test;
   import md5_pkg::*;

   typedef struct {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } msg_item_type;

   typedef struct {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   localparam int unsigned CycleLimit = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   // pending message items and predicted digest words
   msg_item_type    pending_items[$];
   digest_word_type expected_digest[$];

   // local copy of the hash state
   logic [31:0] chain_words[4];
   logic [31:0] msg_block[16];
   logic [63:0] total_bytes;
   int unsigned block_fill;

   int unsigned error_count;
   int unsigned words_checked;
   int unsigned messages_sent;
   int unsigned cycle_count;
   int unsigned hold_cycles;
   bit          stim_done;

   md5_message_digest_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // round constants of the compression, as in rfc 1321
   function automatic logic [31:0] round_const(input int r);
      logic [31:0] tbl[64];
      begin
         tbl = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
         return tbl[r];
      end
   endfunction

   task automatic compress_block();
      logic [31:0] a, b, c, d, f, t;
      int          g, s;
      int          shifts[16];
      begin
         shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
         a = chain_words[0];
         b = chain_words[1];
         c = chain_words[2];
         d = chain_words[3];
         for (int r = 0; r < 64; r++) begin
            s = shifts[(r / 16) * 4 + (r % 4)];
            if (r < 16) begin
               f = (b & c) | (~b & d);
               g = r;
            end else if (r < 32) begin
               f = (b & d) | (c & ~d);
               g = (5 * r + 1) % 16;
            end else if (r < 48) begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end else begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
            t = a + f + round_const(r) + msg_block[g];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (32 - s)));
         end
         chain_words[0] += a;
         chain_words[1] += b;
         chain_words[2] += c;
         chain_words[3] += d;
      end
   endtask

   task automatic absorb_byte(input logic [7:0] v);
      begin
         msg_block[block_fill / 4][(block_fill % 4) * 8 +: 8] = v;
         if (block_fill == 63) begin
            compress_block();
            block_fill = 0;
         end else begin
            block_fill++;
         end
      end
   endtask

   task automatic restart_hash();
      begin
         chain_words = '{IV0, IV1, IV2, IV3};
         foreach (msg_block[i]) msg_block[i] = '0;
         total_bytes = '0;
         block_fill = 0;
      end
   endtask

   // advance the local hash by one accepted item, queue the digest on a last
   task automatic predict_digest(input msg_item_type it);
      logic [63:0]     bit_len;
      digest_word_type dw;
      begin
         if (it.has_byte) begin
            absorb_byte(it.data_byte);
            total_bytes++;
         end
         if (it.is_last) begin
            bit_len = total_bytes << 3;
            absorb_byte(8'h80);
            while (block_fill != 56) absorb_byte(8'h00);
            for (int k = 0; k < 8; k++) absorb_byte(bit_len[8 * k +: 8]);
            for (int k = 0; k < 4; k++) begin
               dw.word = chain_words[k];
               dw.index = 2'(k);
               dw.last = (k == 3);
               expected_digest.push_back(dw);
            end
            restart_hash();
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      begin
         $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
         error_count++;
      end
   endtask

   task automatic add_item(input logic [7:0] v, input logic hb, input logic lst);
      msg_item_type it;
      begin
         it.data_byte = v;
         it.has_byte = hb;
         it.is_last = lst;
         pending_items.push_back(it);
      end
   endtask

   // whole message of n random bytes, last byte optionally carried by the end item
   task automatic add_message(input int n);
      bit tail_byte;
      begin
         tail_byte = (n > 0) && $urandom_range(0, 1);
         for (int i = 0; i < n - tail_byte; i++) begin
            add_item(8'($urandom), 1'b1, 1'b0);
            // occasional empty transfer inside a message
            if ($urandom_range(0, 15) == 0) add_item(8'($urandom), 1'b0, 1'b0);
         end
         add_item(8'($urandom), tail_byte, 1'b1);
      end
   endtask

   // stimulus: directed corners first, then random messages
   initial begin
      int n;
      restart_hash();
      // empty message
      add_item(8'h00, 1'b0, 1'b1);
      // idle transfers that must do nothing, data ignored without a byte
      add_item(8'hff, 1'b0, 1'b0);
      add_item(8'h5a, 1'b0, 1'b0);
      // one byte on the last transfer, both extremes
      add_item(8'h00, 1'b1, 1'b1);
      add_item(8'hff, 1'b1, 1'b1);
      // "abc" with the end carried separately
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b1, 1'b0);
      add_item(8'h00, 1'b0, 1'b1);
      // padding boundaries: 55, 56 and 64 bytes
      add_message(55);
      add_message(56);
      add_message(64);
      // random messages, mostly short, a few over one or two blocks
      while (pending_items.size() < 380) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(57, 140) : $urandom_range(0, 20);
         // keep the total close to the target count
         if (n > 380 - int'(pending_items.size())) n = 380 - int'(pending_items.size());
         add_message(n);
         // stray noise between messages
         if ($urandom_range(0, 3) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      end
      stim_done = 1'b1;
   end

   // driver: bursts of random length separated by random gaps
   int unsigned burst_left;
   int unsigned gap_left;
   always @(posedge clock) begin
      msg_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= '0;
         req_has_byte <= 1'b0;
         req_is_last <= 1'b0;
         burst_left <= $urandom_range(1, 30);
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         // slot free: either the previous transfer completed or nothing offered
         if (req_valid) begin
            it.data_byte = req_data_byte;
            it.has_byte = req_has_byte;
            it.is_last = req_is_last;
            predict_digest(it);
            if (it.is_last) messages_sent++;
         end
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            it = pending_items.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= it.data_byte;
            req_has_byte <= it.has_byte;
            req_is_last <= it.is_last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off early in the run
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles < 900 && messages_sent >= 2) begin
         hold_cycles <= hold_cycles + 1;
         rsp_ready <= 1'b0;
      end else if (cycle_count % 512 < 200) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor: compare each digest word with the oldest prediction
   always @(posedge clock) begin
      digest_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digest.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_digest_word, '0);
         end else begin
            want = expected_digest.pop_front();
            words_checked++;
            if (rsp_digest_word !== want.word)
               report_mismatch("digest_word", rsp_digest_word, want.word);
            if (rsp_word_index !== want.index)
               report_mismatch("word_index", 32'(rsp_word_index), 32'(want.index));
            if (rsp_last_word !== want.last)
               report_mismatch("last_word", 32'(rsp_last_word), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("md5_message_digest_unit_test: FAIL");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      words_checked = 0;
      messages_sent = 0;
      cycle_count = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (pending_items.size() != 0 || req_valid || expected_digest.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (expected_digest.size() != 0) begin
         $display("%0d digest words never arrived", expected_digest.size());
         error_count++;
      end
      $display("covered %0d messages, %0d digest words checked, including empty,",
               messages_sent, words_checked);
      $display("single-byte, padding-boundary and multi-block messages under back-pressure");
      if (error_count == 0) begin
         $display("md5_message_digest_unit_test: PASS");
      end else begin
         $display("md5_message_digest_unit_test: FAIL");
      end
      $finish;
   end
endmodule
